// File: hw/rtl/temporal_direct_mv_scaler_defines.svh
// Assertion macros for the temporal direct vector scaler.
// Both forms sample on i_clk and are switched off while i_rst_n is low.
`ifndef TEMPORAL_DIRECT_MV_SCALER_DEFINES_SVH
`define TEMPORAL_DIRECT_MV_SCALER_DEFINES_SVH

`ifndef NO_ASSERTIONS

// The consequent must hold in the same cycle as the antecedent.
`define TDMVS_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define TDMVS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`else

`define TDMVS_ASSERT_IMPL(lbl, ante, cons)
`define TDMVS_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

// File: hw/rtl/tdmvs_pkg.sv
package tdmvs_pkg;

    // Field widths.
    localparam int POC_W   = 32;
    localparam int MV_W    = 16;
    localparam int DIST_W  = 8;
    localparam int TX_W    = 16;
    localparam int PROD_W  = 24;
    localparam int FAC_W   = 11;
    localparam int SPROD_W = 27;

    // Scaling constants.
    localparam int TX_NUM   = 16384;
    localparam int DIST_MIN = -128;
    localparam int DIST_MAX = 127;
    localparam int FAC_MIN  = -1024;
    localparam int FAC_MAX  = 1023;
    localparam int FAC_RND  = 32;
    localparam int FAC_SH   = 6;
    localparam int MV_RND   = 128;
    localparam int MV_SH    = 8;

    // Stream payload widths.
    localparam int IN_DATA_W  = 3 * POC_W + 2 * MV_W;
    localparam int IN_USER_W  = 2;
    localparam int OUT_DATA_W = 4 * MV_W;

    // Per-item side information that rides along the pipeline.
    typedef struct packed {
        logic                    intra;
        logic                    copy;
        logic signed [MV_W-1:0]  mvx;
        logic signed [MV_W-1:0]  mvy;
    } t_side;

    // Status of the item held in the output register.
    typedef struct packed {
        logic intra;
        logic copy;
    } t_stat;

endpackage

// File: hw/rtl/tdmvs_dist.sv
module tdmvs_dist
    import tdmvs_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_en,
    input  logic                     i_vld,
    input  logic signed [POC_W-1:0]  i_cur_poc,
    input  logic signed [POC_W-1:0]  i_col_pic_poc,
    input  logic signed [POC_W-1:0]  i_ref0_poc,
    input  logic                     i_ref0_long_term,
    input  logic                     i_col_has_ref,
    input  logic signed [MV_W-1:0]   i_col_mvx,
    input  logic signed [MV_W-1:0]   i_col_mvy,
    output logic                     o_vld,
    output logic signed [DIST_W-1:0] o_tb,
    output logic signed [DIST_W-1:0] o_td,
    output t_side                    o_side
);

    logic signed [POC_W:0]    w_db;
    logic signed [POC_W:0]    w_dd;
    logic signed [DIST_W-1:0] n_tb;
    logic signed [DIST_W-1:0] n_td;
    t_side                    n_side;
    logic                     r_vld;
    logic signed [DIST_W-1:0] r_tb;
    logic signed [DIST_W-1:0] r_td;
    t_side                    r_side;

    // Exact distances, one bit wider than the counts so nothing overflows.
    assign w_db = {i_cur_poc[POC_W-1], i_cur_poc} - {i_ref0_poc[POC_W-1], i_ref0_poc};
    assign w_dd = {i_col_pic_poc[POC_W-1], i_col_pic_poc} - {i_ref0_poc[POC_W-1], i_ref0_poc};

    // Saturate both distances to the signed byte range.
    always_comb begin
        if (w_db > DIST_MAX) begin
            n_tb = DIST_W'(DIST_MAX);
        end else if (w_db < DIST_MIN) begin
            n_tb = DIST_W'(DIST_MIN);
        end else begin
            n_tb = DIST_W'(w_db);
        end
        if (w_dd > DIST_MAX) begin
            n_td = DIST_W'(DIST_MAX);
        end else if (w_dd < DIST_MIN) begin
            n_td = DIST_W'(DIST_MIN);
        end else begin
            n_td = DIST_W'(w_dd);
        end
    end

    // Classify the block: intra, plain copy, or scaled.
    always_comb begin
        n_side.intra = !i_col_has_ref;
        n_side.copy  = i_ref0_long_term || (i_col_pic_poc == i_ref0_poc);
        n_side.mvx   = i_col_mvx;
        n_side.mvy   = i_col_mvy;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_tb   <= n_tb;
            r_td   <= n_td;
            r_side <= n_side;
        end
    end

    assign o_vld  = r_vld;
    assign o_tb   = r_tb;
    assign o_td   = r_td;
    assign o_side = r_side;

endmodule

// File: hw/rtl/tdmvs_factor.sv
module tdmvs_factor
    import tdmvs_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_en,
    input  logic                     i_vld,
    input  logic signed [DIST_W-1:0] i_tb,
    input  logic signed [DIST_W-1:0] i_td,
    input  t_side                    i_side,
    output logic                     o_vld,
    output logic signed [FAC_W-1:0]  o_fac,
    output t_side                    o_side
);

    localparam int ROM_N = 2 ** DIST_W;

    logic signed [TX_W-1:0]   w_tx_rom [ROM_N];
    logic [DIST_W-1:0]        w_idx;
    logic signed [PROD_W-1:0] w_rnd;
    logic [2:0]               r_vld;
    logic signed [TX_W-1:0]   r_tx;
    logic signed [DIST_W-1:0] r_tb;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [FAC_W-1:0]  r_fac;
    t_side                    r_side2;
    t_side                    r_side3;
    t_side                    r_side4;
    logic signed [FAC_W-1:0]  n_fac;

    // Reciprocal table indexed by the offset-binary distance; entry for zero is unused.
    for (genvar g = 0; g < ROM_N; g++) begin : g_rom
        localparam int TD   = g + DIST_MIN;
        localparam int HALF = (TD < 0) ? (-TD) / 2 : TD / 2;
        localparam int DIV  = (TD == 0) ? 1 : TD;
        localparam int TX   = (TD == 0) ? 0 : (TX_NUM + HALF) / DIV;
        assign w_tx_rom[g] = TX_W'(TX);
    end

    assign w_idx = {~i_td[DIST_W-1], i_td[DIST_W-2:0]};

    // Stage 2: table lookup.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_tx    <= w_tx_rom[w_idx];
            r_tb    <= i_tb;
            r_side2 <= i_side;
        end
    end

    // Stage 3: distance times reciprocal, both widened to the product width first.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod  <= PROD_W'(r_tb) * PROD_W'(r_tx);
            r_side3 <= r_side2;
        end
    end

    // Stage 4: round, shift and saturate the factor.
    assign w_rnd = (r_prod + PROD_W'(FAC_RND)) >>> FAC_SH;

    always_comb begin
        if (w_rnd > FAC_MAX) begin
            n_fac = FAC_W'(FAC_MAX);
        end else if (w_rnd < FAC_MIN) begin
            n_fac = FAC_W'(FAC_MIN);
        end else begin
            n_fac = FAC_W'(w_rnd);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_fac   <= n_fac;
            r_side4 <= r_side3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[1:0], i_vld};
        end
    end

    assign o_vld  = r_vld[2];
    assign o_fac  = r_fac;
    assign o_side = r_side4;

endmodule

// File: hw/rtl/tdmvs_scale.sv
module tdmvs_scale
    import tdmvs_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_en,
    input  logic                    i_vld,
    input  logic signed [FAC_W-1:0] i_fac,
    input  t_side                   i_side,
    output logic                    o_vld,
    output logic [MV_W-1:0]         o_l0_mvx,
    output logic [MV_W-1:0]         o_l0_mvy,
    output logic [MV_W-1:0]         o_l1_mvx,
    output logic [MV_W-1:0]         o_l1_mvy,
    output t_stat                   o_stat
);

    logic [1:0]                r_vld;
    logic signed [SPROD_W-1:0] r_px;
    logic signed [SPROD_W-1:0] r_py;
    t_side                     r_side5;
    logic signed [SPROD_W-1:0] w_sx;
    logic signed [SPROD_W-1:0] w_sy;
    logic [MV_W-1:0]           n_l0x;
    logic [MV_W-1:0]           n_l0y;
    logic [MV_W-1:0]           n_l1x;
    logic [MV_W-1:0]           n_l1y;
    logic [MV_W-1:0]           r_l0x;
    logic [MV_W-1:0]           r_l0y;
    logic [MV_W-1:0]           r_l1x;
    logic [MV_W-1:0]           r_l1y;
    t_stat                     r_stat;

    // Stage 5: factor times each vector component, both widened to the product width first.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_px    <= SPROD_W'(i_fac) * SPROD_W'($signed(i_side.mvx));
            r_py    <= SPROD_W'(i_fac) * SPROD_W'($signed(i_side.mvy));
            r_side5 <= i_side;
        end
    end

    // Stage 6: round, wrap and pick the result for the block's mode.
    assign w_sx = (r_px + SPROD_W'(MV_RND)) >>> MV_SH;
    assign w_sy = (r_py + SPROD_W'(MV_RND)) >>> MV_SH;

    always_comb begin
        if (r_side5.intra) begin
            n_l0x = '0;
            n_l0y = '0;
            n_l1x = '0;
            n_l1y = '0;
        end else if (r_side5.copy) begin
            n_l0x = r_side5.mvx;
            n_l0y = r_side5.mvy;
            n_l1x = '0;
            n_l1y = '0;
        end else begin
            n_l0x = w_sx[MV_W-1:0];
            n_l0y = w_sy[MV_W-1:0];
            n_l1x = w_sx[MV_W-1:0] - r_side5.mvx;
            n_l1y = w_sy[MV_W-1:0] - r_side5.mvy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_l0x        <= n_l0x;
            r_l0y        <= n_l0y;
            r_l1x        <= n_l1x;
            r_l1y        <= n_l1y;
            r_stat.intra <= r_side5.intra;
            r_stat.copy  <= r_side5.copy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[0], i_vld};
        end
    end

    assign o_vld    = r_vld[1];
    assign o_l0_mvx = r_l0x;
    assign o_l0_mvy = r_l0y;
    assign o_l1_mvx = r_l1x;
    assign o_l1_mvy = r_l1y;
    assign o_stat   = r_stat;

endmodule

// File: hw/rtl/temporal_direct_mv_scaler.sv
// Channel   Dir  Fields (tdata / tuser, lowest bit first)
// s_axis    in   cur_poc, col_pic_poc, ref0_poc, col_mvx, col_mvy / ref0_long_term, col_has_ref
// m_axis    out  l0_mvx, l0_mvy, l1_mvx, l1_mvy / none
//
// A request passes six register stages, the last of which holds the result for the sink;
// one request can enter every cycle while the pipeline is not stalled. The stages are:
// distance clip, reciprocal table, distance product, factor clip, vector products,
// rounding and mode select.
// The whole pipeline advances together; it stalls only while the output register
// holds a result that the sink has not taken, and then nothing is lost or repeated.
// Reset (i_rst_n low at a clock edge) clears the valid bits of every stage.
`include "temporal_direct_mv_scaler_defines.svh"

module temporal_direct_mv_scaler
    import tdmvs_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // cur_poc, col_pic_poc, ref0_poc, col_mvx, col_mvy
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // ref0_long_term, col_has_ref
    input  logic [IN_USER_W-1:0]  s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // l0_mvx, l0_mvy, l1_mvx, l1_mvy
    output logic [OUT_DATA_W-1:0] m_axis_tdata
);

    logic                     w_en;
    logic                     w_vld1;
    logic signed [DIST_W-1:0] w_tb;
    logic signed [DIST_W-1:0] w_td;
    t_side                    w_side1;
    logic                     w_vld4;
    logic signed [FAC_W-1:0]  w_fac;
    t_side                    w_side4;
    logic [MV_W-1:0]          w_l0x;
    logic [MV_W-1:0]          w_l0y;
    logic [MV_W-1:0]          w_l1x;
    logic [MV_W-1:0]          w_l1y;
    t_stat                    w_stat;

    // Advance when the output register is empty or being emptied.
    assign w_en          = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = w_en;

    tdmvs_dist u_dist (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_en             (w_en),
        .i_vld            (s_axis_tvalid),
        .i_cur_poc        (s_axis_tdata[POC_W-1:0]),
        .i_col_pic_poc    (s_axis_tdata[2*POC_W-1:POC_W]),
        .i_ref0_poc       (s_axis_tdata[3*POC_W-1:2*POC_W]),
        .i_ref0_long_term (s_axis_tuser[0]),
        .i_col_has_ref    (s_axis_tuser[1]),
        .i_col_mvx        (s_axis_tdata[3*POC_W+MV_W-1:3*POC_W]),
        .i_col_mvy        (s_axis_tdata[3*POC_W+2*MV_W-1:3*POC_W+MV_W]),
        .o_vld            (w_vld1),
        .o_tb             (w_tb),
        .o_td             (w_td),
        .o_side           (w_side1)
    );

    tdmvs_factor u_factor (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (w_vld1),
        .i_tb    (w_tb),
        .i_td    (w_td),
        .i_side  (w_side1),
        .o_vld   (w_vld4),
        .o_fac   (w_fac),
        .o_side  (w_side4)
    );

    tdmvs_scale u_scale (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_en),
        .i_vld    (w_vld4),
        .i_fac    (w_fac),
        .i_side   (w_side4),
        .o_vld    (m_axis_tvalid),
        .o_l0_mvx (w_l0x),
        .o_l0_mvy (w_l0y),
        .o_l1_mvx (w_l1x),
        .o_l1_mvy (w_l1y),
        .o_stat   (w_stat)
    );

    assign m_axis_tdata = {w_l1y, w_l1x, w_l0y, w_l0x};

    // An intra block gives an all-zero result.
    `TDMVS_ASSERT_IMPL(a_intra_zero, m_axis_tvalid && w_stat.intra, m_axis_tdata == '0)

    // A copied vector has a zero list-1 vector.
    `TDMVS_ASSERT_IMPL(a_copy_l1_zero, m_axis_tvalid && w_stat.copy, m_axis_tdata[4*MV_W-1:2*MV_W] == '0)

    // With nothing waiting at the output the block must take a new request.
    `TDMVS_ASSERT_IMPL(a_ready_when_empty, !m_axis_tvalid, s_axis_tready)

    // A result the sink did not take is still offered in the next cycle.
    `TDMVS_ASSERT_NEXT(a_hold_result, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)

endmodule

// File: verif/temporal_direct_mv_scaler_test.sv
`timescale 1ns / 100ps

// One request to the scaler: the fields of a single 4x4 block.
typedef struct packed {
    logic signed [tdmvs_pkg::POC_W-1:0] cur_poc;
    logic signed [tdmvs_pkg::POC_W-1:0] col_pic_poc;
    logic signed [tdmvs_pkg::POC_W-1:0] ref0_poc;
    logic                               ref0_long_term;
    logic                               col_has_ref;
    logic signed [tdmvs_pkg::MV_W-1:0]  col_mvx;
    logic signed [tdmvs_pkg::MV_W-1:0]  col_mvy;
} t_block;

// Keeps the direct vectors predicted for accepted requests, oldest first,
// and compares each result leaving the block against them.
class mv_scoreboard;
    logic [63:0] pending_vectors[$];
    int          mismatch_count;

    function new();
        mismatch_count = 0;
    endfunction

    static function longint clamp(longint v, longint lo, longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    // Temporal direct scaling; the result is packed as the output tdata,
    // {l1_mvy, l1_mvx, l0_mvy, l0_mvx}, each wrapped to 16 bits.
    static function logic [63:0] scale_direct_mv(t_block b);
        longint cur, colp, r0, mx, my;
        longint tb, td, half, tx, fac;
        longint l0x, l0y, l1x, l1y;
        cur  = b.cur_poc;
        colp = b.col_pic_poc;
        r0   = b.ref0_poc;
        mx   = b.col_mvx;
        my   = b.col_mvy;
        if (!b.col_has_ref) begin
            // Intra co-located block gives zero vectors.
            l0x = 0;
            l0y = 0;
            l1x = 0;
            l1y = 0;
        end else if (b.ref0_long_term || colp == r0) begin
            // Long-term reference or zero distance: plain copy.
            l0x = mx;
            l0y = my;
            l1x = 0;
            l1y = 0;
        end else begin
            tb   = clamp(cur - r0, -128, 127);
            td   = clamp(colp - r0, -128, 127);
            half = td / 2;
            if (half < 0) begin
                half = -half;
            end
            tx  = (16384 + half) / td;
            fac = clamp((tb * tx + 32) >>> 6, -1024, 1023);
            l0x = (fac * mx + 128) >>> 8;
            l0y = (fac * my + 128) >>> 8;
            l1x = l0x - mx;
            l1y = l0y - my;
        end
        return {l1y[15:0], l1x[15:0], l0y[15:0], l0x[15:0]};
    endfunction

    function void note_request(t_block b);
        pending_vectors.push_back(scale_direct_mv(b));
    endfunction

    function void check_result(logic [63:0] got);
        logic [63:0] want;
        string       fname;
        if (pending_vectors.size() == 0) begin
            $display("%0t: unexpected result %h", $time, got);
            mismatch_count++;
            return;
        end
        want = pending_vectors.pop_front();
        for (int k = 0; k < 4; k++) begin
            if (want[16*k +: 16] !== got[16*k +: 16]) begin
                case (k)
                    0: fname = "l0_mvx";
                    1: fname = "l0_mvy";
                    2: fname = "l1_mvx";
                    default: fname = "l1_mvy";
                endcase
                $display("%0t: %s expected %0d got %0d", $time, fname,
                         $signed(want[16*k +: 16]), $signed(got[16*k +: 16]));
                mismatch_count++;
            end
        end
    endfunction
endclass

module temporal_direct_mv_scaler_test;
    import tdmvs_pkg::IN_DATA_W;
    import tdmvs_pkg::IN_USER_W;
    import tdmvs_pkg::OUT_DATA_W;

    localparam int POC_LO       = 32'sh8000_0000;
    localparam int POC_HI       = 32'sh7fff_ffff;
    localparam int HOLD_CYCLES  = 64;
    localparam int DRAIN_CYCLES = 20;
    localparam int STALL_LIMIT  = 1000;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    // cur_poc, col_pic_poc, ref0_poc, col_mvx, col_mvy
    logic [IN_DATA_W-1:0]  s_axis_tdata;
    // ref0_long_term, col_has_ref
    logic [IN_USER_W-1:0]  s_axis_tuser;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    // l0_mvx, l0_mvy, l1_mvx, l1_mvy
    logic [OUT_DATA_W-1:0] m_axis_tdata;

    mv_scoreboard sb;
    int           src_idle_pct;
    int           snk_idle_pct;
    int           hold_requests;
    int           hold_served;
    int           quiet_cycles;

    temporal_direct_mv_scaler u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        i_clk = 1'b0;
    end

    always #5 i_clk = ~i_clk;

    function automatic t_block make_block(int cur, int colp, int r0, bit lt, bit has_ref,
                                          shortint mx, shortint my);
        t_block b;
        b.cur_poc        = cur;
        b.col_pic_poc    = colp;
        b.ref0_poc       = r0;
        b.ref0_long_term = lt;
        b.col_has_ref    = has_ref;
        b.col_mvx        = mx;
        b.col_mvy        = my;
        return b;
    endfunction

    // Mostly nearby picture order counts so that the scaling path is used,
    // with some fully random counts, zero co-located distances and intra blocks.
    function automatic t_block random_block();
        t_block b;
        int     mode;
        mode             = $urandom_range(9);
        b.ref0_poc       = $urandom;
        b.ref0_long_term = ($urandom_range(9) == 0);
        b.col_has_ref    = ($urandom_range(15) != 0);
        if (mode == 0) begin
            b.cur_poc     = $urandom;
            b.col_pic_poc = $urandom;
        end else begin
            b.cur_poc     = b.ref0_poc + (int'($urandom_range(400)) - 200);
            b.col_pic_poc = (mode == 1) ? b.ref0_poc
                                        : b.ref0_poc + (int'($urandom_range(400)) - 200);
        end
        if ($urandom_range(1) == 0) begin
            b.col_mvx = 16'($urandom);
            b.col_mvy = 16'($urandom);
        end else begin
            b.col_mvx = 16'(int'($urandom_range(1024)) - 512);
            b.col_mvy = 16'(int'($urandom_range(1024)) - 512);
        end
        return b;
    endfunction

    // Offers one request, starting and ending at a falling edge.
    task automatic send_block(t_block b);
        while ($urandom_range(99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {b.col_mvy, b.col_mvx, b.ref0_poc, b.col_pic_poc, b.cur_poc};
        s_axis_tuser  <= {b.col_has_ref, b.ref0_long_term};
        @(posedge i_clk);
        while (!s_axis_tready) begin
            @(posedge i_clk);
        end
        sb.note_request(b);
        @(negedge i_clk);
    endtask

    task automatic send_random(int count);
        for (int n = 0; n < count; n++) begin
            send_block(random_block());
        end
    endtask

    // Sink ready, with random idling and the occasional long hold-off.
    initial begin
        int hold_left;
        hold_left     = 0;
        hold_served   = 0;
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_served != hold_requests) begin
                hold_served = hold_requests;
                hold_left   = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= ($urandom_range(99) >= snk_idle_pct);
            end
        end
    end

    // Result checking and the watchdog on cycles without any request moving.
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            sb.check_result(m_axis_tdata);
        end
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("%0t: no progress for %0d cycles", $time, quiet_cycles);
                $display("temporal_direct_mv_scaler_test NOT OK");
                $finish;
            end
        end
    end

    initial begin
        sb            = new();
        quiet_cycles  = 0;
        hold_requests = 0;
        src_idle_pct  = 33;
        snk_idle_pct  = 47;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Intra blocks with extreme vectors and counts.
        send_block(make_block(10, 20, 0, 0, 0, -32768, 32767));
        send_block(make_block(POC_HI, POC_LO, 0, 1, 0, 32767, -32768));
        // Copy cases: long-term reference and zero co-located distance.
        send_block(make_block(5, 9, 1, 1, 1, -32768, 32767));
        send_block(make_block(100, -7, -7, 0, 1, 1234, -4321));
        send_block(make_block(POC_LO, POC_HI, POC_HI, 0, 1, 32767, -1));
        // Ordinary scaling.
        send_block(make_block(4, 8, 0, 0, 1, 100, -100));
        // Factor clipped high and low, vectors wrapping to 16 bits.
        send_block(make_block(1000, 1, 0, 0, 1, 32767, -32768));
        send_block(make_block(-1000, 1, 0, 0, 1, 32767, -32768));
        send_block(make_block(3, -1, 0, 0, 1, -5, 7));
        // Distances beyond 32 bits and at the clip limits.
        send_block(make_block(POC_HI, POC_LO, POC_HI - 10, 0, 1, 2000, -2000));
        send_block(make_block(POC_LO, POC_HI, POC_LO + 10, 0, 1, -2000, 2000));
        send_block(make_block(POC_HI, POC_LO, POC_LO + 1, 0, 1, -32768, -32768));
        send_block(make_block(127, -128, 0, 0, 1, 32767, 32767));
        send_block(make_block(-128, 127, 0, 0, 1, -32768, 32767));
        // Zero vector, unit vectors, zero current distance, odd distances.
        send_block(make_block(2, 4, 0, 0, 1, 0, 0));
        send_block(make_block(1, 3, 0, 0, 1, -1, 1));
        send_block(make_block(0, 5, 0, 0, 1, 300, -300));
        send_block(make_block(2, -3, 0, 0, 1, 21845, -21846));
        send_block(make_block(-1, 32'sh5555_5555, 32'shaaaa_aaaa, 0, 1, -21846, 21845));
        send_block(make_block(32'shaaaa_aaaa, -1, 32'sh5555_5555, 1, 1, 77, -77));

        send_random(350);

        // Swap the idling, and hold the sink off while requests keep coming.
        src_idle_pct = 47;
        snk_idle_pct = 33;
        hold_requests++;
        send_random(350);

        src_idle_pct = 0;
        snk_idle_pct = 0;
        send_random(300);
        s_axis_tvalid <= 1'b0;

        while (sb.pending_vectors.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (sb.mismatch_count == 0) begin
            $display("temporal_direct_mv_scaler_test OK");
        end else begin
            $display("temporal_direct_mv_scaler_test NOT OK");
        end
        $finish;
    end

endmodule

// File: temporal_direct_mv_scaler.f
+incdir+hw/rtl
hw/rtl/tdmvs_pkg.sv
hw/rtl/tdmvs_dist.sv
hw/rtl/tdmvs_factor.sv
hw/rtl/tdmvs_scale.sv
hw/rtl/temporal_direct_mv_scaler.sv
verif/temporal_direct_mv_scaler_test.sv
